[rtl/fclr_pkg.sv]
// shared types, codes and the header lookup for the framed channel link receiver
// no dependencies
`default_nettype none

package fclr_pkg;

  // configuration port
  localparam int unsigned AddrWidth    = 3;
  localparam int unsigned DataWidth    = 32;
  localparam logic        RegUnitMode  = 1'b0;
  localparam logic        RegTimeoutMs = 1'b1;
  localparam logic [15:0] TimeoutReset = 16'd1000;

  // link codes
  localparam logic [7:0] StopCode = 8'h41;
  localparam logic [7:0] HeaderCodes [8] = '{8'h77, 8'hFD, 8'h99, 8'hAA,
                                              8'hBB, 8'hFE, 8'hDD, 8'hEE};

  typedef enum logic [1:0] {
    OP_BYTE    = 2'd0,
    OP_TX_DONE = 2'd1,
    OP_TICK    = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    KIND_VALUE  = 2'd0,
    KIND_STATUS = 2'd1,
    KIND_TURN   = 2'd2
  } kind_e;

  typedef enum logic {
    MODE_VALUE  = 1'b0,
    MODE_STATUS = 1'b1
  } mode_e;

  typedef struct packed {
    mode_e       unit_mode;
    logic [15:0] timeout_ms;
  } cfg_t;

  // control state of the receiver
  typedef struct packed {
    logic        turn_ours;
    logic        header_pending;
    logic [2:0]  current_channel;
    logic [1:0]  byte_position;
    logic [15:0] alarm_bits;
    logic [3:0]  range_flags;
    logic [15:0] listen_elapsed;
  } state_t;

  typedef struct packed {
    kind_e       result_kind;
    logic [2:0]  channel;
    logic [31:0] value_word;
    logic [15:0] alarm_mask;
    logic [3:0]  range_bits;
    logic        turn_is_ours;
  } result_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] chan;
  } hdr_t;

  // match a byte against the eight header codes
  function automatic hdr_t header_lookup(input logic [7:0] b);
    hdr_t r;
    r = '0;
    for (int i = 7; i >= 0; i--) begin
      if (HeaderCodes[i] == b) begin
        r.hit  = 1'b1;
        r.chan = 3'(i);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/fclr_in_if.sv]
// input channel: opcode and received byte with valid/ready
// depends on nothing
`default_nettype none

interface fclr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] rx_byte;

  modport source (output valid, output opcode, output rx_byte, input ready);
  modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

`default_nettype wire

[rtl/fclr_out_if.sv]
// result channel: one result beat with valid/ready
// depends on nothing
`default_nettype none

interface fclr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [2:0]  channel;
  logic [31:0] value_word;
  logic [15:0] alarm_mask;
  logic [3:0]  range_bits;
  logic        turn_is_ours;

  modport source (output valid, output result_kind, output channel, output value_word,
                  output alarm_mask, output range_bits, output turn_is_ours,
                  input ready);
  modport sink   (input valid, input result_kind, input channel, input value_word,
                  input alarm_mask, input range_bits, input turn_is_ours,
                  output ready);
endinterface

`default_nettype wire

[rtl/fclr_cfg.sv]
// APB-style register file: unit mode and listening timeout
// depends on fclr_pkg
`default_nettype none

module fclr_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [fclr_pkg::AddrWidth-1:0] paddr,
  input  wire logic [fclr_pkg::DataWidth-1:0] pwdata,
  output logic      [fclr_pkg::DataWidth-1:0] prdata,
  output logic                               pready,
  output fclr_pkg::cfg_t                     cfg_o
);

  fclr_pkg::cfg_t cfg_q, cfg_d;
  logic           wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (paddr[2])
        fclr_pkg::RegUnitMode:  cfg_d.unit_mode  = fclr_pkg::mode_e'(pwdata[0]);
        fclr_pkg::RegTimeoutMs: cfg_d.timeout_ms = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.unit_mode  <= fclr_pkg::MODE_VALUE;
      cfg_q.timeout_ms <= fclr_pkg::TimeoutReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      fclr_pkg::RegUnitMode:  prdata = {{(fclr_pkg::DataWidth-1){1'b0}}, cfg_q.unit_mode};
      fclr_pkg::RegTimeoutMs: prdata = {{(fclr_pkg::DataWidth-16){1'b0}}, cfg_q.timeout_ms};
      default: ;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[rtl/fclr_step.sv]
// next-state and result logic for one beat of the link receiver
// depends on fclr_pkg
`default_nettype none

module fclr_step (
  input  wire fclr_pkg::cfg_t   cfg_i,
  input  wire fclr_pkg::state_t st_i,
  input  wire logic [7:0]    word_b0_i,
  input  wire logic [7:0]    word_b1_i,
  input  wire logic [7:0]    word_b2_i,
  input  wire logic [1:0]    opcode_i,
  input  wire logic [7:0]    rx_byte_i,
  output fclr_pkg::state_t   st_o,
  output logic               wb_en_o,
  output logic [1:0]         wb_idx_o,
  output logic               res_v_o,
  output fclr_pkg::result_t  res_o
);

  fclr_pkg::hdr_t  hdr;
  fclr_pkg::kind_e kind;
  logic [31:0]     word;

  assign hdr = fclr_pkg::header_lookup(rx_byte_i);

  // per-opcode state update
  always_comb begin
    st_o     = st_i;
    wb_en_o  = 1'b0;
    wb_idx_o = st_i.byte_position;
    res_v_o  = 1'b0;
    kind     = fclr_pkg::KIND_TURN;
    word     = '0;
    unique case (fclr_pkg::op_e'(opcode_i))
      fclr_pkg::OP_BYTE: begin
        priority if (rx_byte_i == fclr_pkg::StopCode) begin
          st_o.turn_ours     = 1'b1;
          st_o.byte_position = '0;
          res_v_o            = 1'b1;
          kind               = fclr_pkg::KIND_TURN;
        end else if (st_i.turn_ours) begin
          st_o.byte_position = '0;
        end else if (st_i.header_pending) begin
          st_o.byte_position = '0;
          if (hdr.hit) begin
            st_o.current_channel = hdr.chan;
            st_o.header_pending  = 1'b0;
          end
        end else if (cfg_i.unit_mode == fclr_pkg::MODE_VALUE) begin
          if (st_i.byte_position != 2'd3) begin
            wb_en_o            = 1'b1;
            st_o.byte_position = st_i.byte_position + 2'd1;
          end else begin
            st_o.byte_position  = '0;
            st_o.header_pending = 1'b1;
            res_v_o             = 1'b1;
            kind                = fclr_pkg::KIND_VALUE;
            word                = {word_b0_i, word_b1_i, word_b2_i, rx_byte_i};
          end
        end else begin
          // status byte: bit 0 high alarm, bit 1 low alarm, bit 2 range
          st_o.alarm_bits[{1'b1, st_i.current_channel}] = rx_byte_i[0];
          st_o.alarm_bits[{1'b0, st_i.current_channel}] = rx_byte_i[1];
          if (!st_i.current_channel[2]) begin
            st_o.range_flags[st_i.current_channel[1:0]] = rx_byte_i[2];
          end
          st_o.header_pending = 1'b1;
          res_v_o             = 1'b1;
          kind                = fclr_pkg::KIND_STATUS;
        end
      end
      fclr_pkg::OP_TX_DONE: begin
        st_o.turn_ours      = 1'b0;
        st_o.listen_elapsed = '0;
      end
      fclr_pkg::OP_TICK: begin
        if (cfg_i.unit_mode == fclr_pkg::MODE_VALUE && !st_i.turn_ours) begin
          if (st_i.listen_elapsed >= cfg_i.timeout_ms) begin
            st_o.turn_ours      = 1'b1;
            st_o.listen_elapsed = '0;
            res_v_o             = 1'b1;
            kind                = fclr_pkg::KIND_TURN;
          end else begin
            st_o.listen_elapsed = st_i.listen_elapsed + 16'd1;
          end
        end
      end
      default: ;
    endcase
  end

  // result fields reflect the state after the beat
  always_comb begin
    res_o.result_kind  = kind;
    res_o.channel      = st_o.current_channel;
    res_o.value_word   = word;
    res_o.alarm_mask   = st_o.alarm_bits;
    res_o.range_bits   = st_o.range_flags;
    res_o.turn_is_ours = st_o.turn_ours;
  end

endmodule

`default_nettype wire

[rtl/framed_channel_link_receiver_unit.sv]
// Framed channel link receiver, top level.
// Path: input register, then result register, which takes the beat when free or draining.
// Throughput: one beat per cycle unless a result waits unread; input refills as results drain.
// Reset: rst_ni low gives the turn to this side, waits for a header, clears counters and flags
// and returns the config to defaults.
// Depends on fclr_pkg, fclr_in_if, fclr_out_if, fclr_cfg and fclr_step.
`default_nettype none

module framed_channel_link_receiver_unit (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  fclr_in_if.sink                             in_i,
  fclr_out_if.source                          out_o,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [fclr_pkg::AddrWidth-1:0] paddr,
  input  wire logic [fclr_pkg::DataWidth-1:0] pwdata,
  output logic      [fclr_pkg::DataWidth-1:0] prdata,
  output logic                                pready
);

  fclr_pkg::cfg_t    cfg;
  fclr_pkg::state_t  st_q, st_d;
  fclr_pkg::result_t res, res_q;
  logic [7:0]        word_q [3];
  logic              in_v_q;
  logic [1:0]        op_q;
  logic [7:0]        byte_q;
  logic              out_v_q;
  logic              adv;
  logic              wb_en;
  logic [1:0]        wb_idx;
  logic              res_v;

  fclr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // the held beat moves on when the result register is free or draining
  assign adv        = in_v_q & (~out_v_q | out_o.ready);
  assign in_i.ready = ~in_v_q | adv;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_v_q <= 1'b1;
    end else if (adv) begin
      in_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      op_q   <= in_i.opcode;
      byte_q <= in_i.rx_byte;
    end
  end

  fclr_step u_step (
    .cfg_i     (cfg),
    .st_i      (st_q),
    .word_b0_i (word_q[0]),
    .word_b1_i (word_q[1]),
    .word_b2_i (word_q[2]),
    .opcode_i  (op_q),
    .rx_byte_i (byte_q),
    .st_o      (st_d),
    .wb_en_o   (wb_en),
    .wb_idx_o  (wb_idx),
    .res_v_o   (res_v),
    .res_o     (res)
  );

  // receiver state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.turn_ours       <= 1'b1;
      st_q.header_pending  <= 1'b1;
      st_q.current_channel <= '0;
      st_q.byte_position   <= '0;
      st_q.alarm_bits      <= '0;
      st_q.range_flags     <= '0;
      st_q.listen_elapsed  <= '0;
    end else if (adv) begin
      st_q <= st_d;
    end
  end

  // word bytes collected ahead of the last byte
  always_ff @(posedge clk_i) begin
    if (adv && wb_en) begin
      word_q[wb_idx] <= byte_q;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= res_v;
    end else if (out_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && res_v) begin
      res_q <= res;
    end
  end

  assign out_o.valid        = out_v_q;
  assign out_o.result_kind  = res_q.result_kind;
  assign out_o.channel      = res_q.channel;
  assign out_o.value_word   = res_q.value_word;
  assign out_o.alarm_mask   = res_q.alarm_mask;
  assign out_o.range_bits   = res_q.range_bits;
  assign out_o.turn_is_ours = res_q.turn_is_ours;

  // a turn claim always leaves the turn with us
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && res_q.result_kind == fclr_pkg::KIND_TURN) |-> res_q.turn_is_ours)
    else $error("turn claim reported without the turn");

  // only value results carry a word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && res_q.result_kind != fclr_pkg::KIND_VALUE) |-> (res_q.value_word == '0))
    else $error("word on a non-value result");

  // a word completes only in value mode after a header
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && res_v && res.result_kind == fclr_pkg::KIND_VALUE) |->
      (cfg.unit_mode == fclr_pkg::MODE_VALUE && !st_q.header_pending &&
       st_q.byte_position == 2'd3))
    else $error("value word out of sequence");

  // in status mode the listen counter never counts up
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg.unit_mode == fclr_pkg::MODE_STATUS && $past(cfg.unit_mode == fclr_pkg::MODE_STATUS))
      |-> ($stable(st_q.listen_elapsed) || st_q.listen_elapsed == '0))
    else $error("listen counter moved in status mode");

endmodule

`default_nettype wire
